// ===== src/rdc_pkg.sv =====
// ----------------------------------------------------------------------------
// rdc_pkg
// shared types and constants for the radix digit converter
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_W     = 63;  // input value width
  localparam int DIGIT_W     = 4;   // one digit, base up to 16
  localparam int BASE_W      = 5;   // target base register width
  localparam int DIV_W       = 64;  // dividend width, value padded to whole steps
  localparam int DIV_BITS    = 8;   // quotient bits retired per divider cycle
  localparam int DIV_STEPS   = DIV_W / DIV_BITS;
  localparam int STEP_CNT_W  = $clog2(DIV_STEPS);
  localparam int RESULT_CAP  = 63;  // most digits one item may produce
  localparam int DIG_CNT_W   = 6;   // holds up to RESULT_CAP

  localparam logic [BASE_W-1:0] BASE_MIN   = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 5'd16;
  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

  localparam logic ACT_INTEGER  = 1'b0;
  localparam logic ACT_FRACTION = 1'b1;

  // result of one divider cycle
  typedef struct packed {
    logic [DIV_W-1:0]   quot;
    logic [DIGIT_W-1:0] rem;
  } rdc_div_t;

endpackage

// ===== src/radix_digit_converter_unit.sv =====
// ----------------------------------------------------------------------------
// radix_digit_converter_unit
// breaks an integer or a fixed-point fraction into digits of base 2 to 16
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------------
//  in      | in  | in_tvalid/in_tready  | tuser: action, tdata: value
//  out     | out | out_tvalid/out_tready| tdata: digit, tlast: is_last
//  cfg     | in  | cfg_wr_en            | cfg_wr_data: target_base
//
//  integer beat: per digit, divider steps retire 8 quotient bits each through
//  the shared alu until the whole dividend is done, then one hand-off; up to 63 digits
//  fraction beat: per digit, one multiply, then one hand-off
//  one input beat at a time; in_tready is high only while the sequencer idles,
//  but the last digit may still wait in the output register meanwhile
//  a stalled output holds the sequencer in its hand-off state
//  rst_n is synchronous, active low; base resets to 10
// ----------------------------------------------------------------------------
module radix_digit_converter_unit #(
  parameter int MAX_FRACTION_DIGITS = 45,
  parameter int FRACTION_BITS       = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [rdc_pkg::BASE_W-1:0] cfg_wr_data,   // target_base
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [63:0]                in_tdata,      // [62:0] value, [63] zero
  input  logic                       in_tuser,      // [0] action
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,     // [3:0] digit, [7:4] zero
  output logic                       out_tlast      // is_last
);
  import rdc_pkg::*;

  localparam int FRAC_LIMIT = (MAX_FRACTION_DIGITS > RESULT_CAP) ? RESULT_CAP
                                                                 : MAX_FRACTION_DIGITS;
  localparam logic [DIG_CNT_W-1:0] FRAC_LIMIT_C = DIG_CNT_W'(FRAC_LIMIT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_PUT
  } state_t;

  // registers
  state_t                  state_r,     state_nxt;
  logic [BASE_W-1:0]       cfg_base_r,  cfg_base_nxt;
  logic [BASE_W-1:0]       base_r,      base_nxt;
  logic                    action_r,    action_nxt;
  logic [DIV_W-1:0]        quot_r,      quot_nxt;
  logic [DIGIT_W-1:0]      rem_r,       rem_nxt;
  logic [FRACTION_BITS-1:0] frac_r,     frac_nxt;
  logic [STEP_CNT_W-1:0]   step_r,      step_nxt;
  logic [DIG_CNT_W-1:0]    ndig_r,      ndig_nxt;
  logic [DIGIT_W-1:0]      pend_dig_r,  pend_dig_nxt;
  logic                    pend_last_r, pend_last_nxt;
  logic                    out_vld_r,   out_vld_nxt;
  logic [DIGIT_W-1:0]      out_dig_r,   out_dig_nxt;
  logic                    out_last_r,  out_last_nxt;

  // alu
  rdc_div_t                 div_res;
  logic [DIGIT_W-1:0]       mul_digit;
  logic [FRACTION_BITS-1:0] mul_frac;

  logic                     in_acc;
  logic                     out_free;
  logic [BASE_W-1:0]        eff_base;
  logic [DIG_CNT_W-1:0]     ndig_inc;

  rdc_alu #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_alu (
    .base      (base_r),
    .div_quot  (quot_r),
    .div_rem   (rem_r),
    .frac      (frac_r),
    .div_res   (div_res),
    .mul_digit (mul_digit),
    .mul_frac  (mul_frac)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_vld_r || out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_dig_r};
  assign out_tlast  = out_last_r;
  assign ndig_inc   = ndig_r + DIG_CNT_W'(1);

  // out-of-range base is clamped to 2..16
  always_comb begin
    if (cfg_base_r < BASE_MIN) begin
      eff_base = BASE_MIN;
    end else if (cfg_base_r > BASE_MAX) begin
      eff_base = BASE_MAX;
    end else begin
      eff_base = cfg_base_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cfg_base_nxt  = cfg_wr_en ? cfg_wr_data : cfg_base_r;
    base_nxt      = base_r;
    action_nxt    = action_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    frac_nxt      = frac_r;
    step_nxt      = step_r;
    ndig_nxt      = ndig_r;
    pend_dig_nxt  = pend_dig_r;
    pend_last_nxt = pend_last_r;
    out_vld_nxt   = out_vld_r;
    out_dig_nxt   = out_dig_r;
    out_last_nxt  = out_last_r;

    // output register drains independently of the sequencer
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          base_nxt   = eff_base;
          action_nxt = in_tuser;
          quot_nxt   = {1'b0, in_tdata[VALUE_W-1:0]};
          rem_nxt    = '0;
          frac_nxt   = in_tdata[FRACTION_BITS-1:0];
          step_nxt   = '0;
          ndig_nxt   = '0;
          if (in_tuser == ACT_INTEGER) begin
            if (in_tdata[VALUE_W-1:0] == '0) begin
              // zero integer: single digit 0
              pend_dig_nxt  = '0;
              pend_last_nxt = 1'b1;
              state_nxt     = S_PUT;
            end else begin
              state_nxt = S_DIV;
            end
          end else if (in_tdata[FRACTION_BITS-1:0] != '0) begin
            state_nxt = S_MUL;
          end
          // zero fraction gives no digits, stay idle
        end
      end

      S_DIV: begin
        quot_nxt = div_res.quot;
        rem_nxt  = div_res.rem;
        step_nxt = step_r + STEP_CNT_W'(1);
        if (step_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
          pend_dig_nxt  = div_res.rem;
          pend_last_nxt = (div_res.quot == '0);
          state_nxt     = S_PUT;
        end
      end

      S_MUL: begin
        frac_nxt      = mul_frac;
        ndig_nxt      = ndig_inc;
        pend_dig_nxt  = mul_digit;
        pend_last_nxt = (mul_frac == '0) || (ndig_inc == FRAC_LIMIT_C);
        state_nxt     = S_PUT;
      end

      S_PUT: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_dig_nxt  = pend_dig_r;
          out_last_nxt = pend_last_r;
          if (pend_last_r) begin
            state_nxt = S_IDLE;
          end else if (action_r == ACT_INTEGER) begin
            // next digit divides the quotient afresh
            rem_nxt   = '0;
            step_nxt  = '0;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cfg_base_r <= BASE_RESET;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cfg_base_r <= cfg_base_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    base_r      <= base_nxt;
    action_r    <= action_nxt;
    quot_r      <= quot_nxt;
    rem_r       <= rem_nxt;
    frac_r      <= frac_nxt;
    step_r      <= step_nxt;
    ndig_r      <= ndig_nxt;
    pend_dig_r  <= pend_dig_nxt;
    pend_last_r <= pend_last_nxt;
    out_dig_r   <= out_dig_nxt;
    out_last_r  <= out_last_nxt;
  end

endmodule

// ===== src/rdc_alu.sv =====
// ----------------------------------------------------------------------------
// rdc_alu
// shared arithmetic unit: several restoring divide steps by the base, or one
// multiply of the fraction by the base
// ----------------------------------------------------------------------------
module rdc_alu #(
  parameter int FRACTION_BITS = 48
) (
  input  logic [rdc_pkg::BASE_W-1:0]  base,
  input  logic [rdc_pkg::DIV_W-1:0]   div_quot,
  input  logic [rdc_pkg::DIGIT_W-1:0] div_rem,
  input  logic [FRACTION_BITS-1:0]    frac,
  output rdc_pkg::rdc_div_t           div_res,
  output logic [rdc_pkg::DIGIT_W-1:0] mul_digit,
  output logic [FRACTION_BITS-1:0]    mul_frac
);
  import rdc_pkg::*;

  localparam int PROD_W = FRACTION_BITS + BASE_W;

  logic [DIV_W-1:0]  quot;
  logic [BASE_W-1:0] rem;
  logic [BASE_W-1:0] trial;
  logic [PROD_W-1:0] prod;

  // restoring division, msb first; remainder stays below the base
  always_comb begin
    quot = div_quot;
    rem  = {1'b0, div_rem};
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem[DIGIT_W-1:0], quot[DIV_W-1]};
      quot  = {quot[DIV_W-2:0], 1'b0};
      if (trial >= base) begin
        trial   = trial - base;
        quot[0] = 1'b1;
      end
      rem = trial;
    end
    div_res.quot = quot;
    div_res.rem  = rem[DIGIT_W-1:0];
  end

  // fraction times base: integer part is the digit, low bits carry on
  assign prod      = {{BASE_W{1'b0}}, frac} * {{FRACTION_BITS{1'b0}}, base};
  assign mul_digit = prod[FRACTION_BITS+DIGIT_W-1:FRACTION_BITS];
  assign mul_frac  = prod[FRACTION_BITS-1:0];

endmodule

// ===== bench/radix_digit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_checker
// watches the input, result and base channels of the radix digit converter,
// works out the digit sequence of every accepted input beat and compares each
// result beat with the oldest digit still owed
// ----------------------------------------------------------------------------
module radix_digit_checker #(
  parameter int MAX_FRACTION_DIGITS = 45,
  parameter int FRACTION_BITS       = 48
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [rdc_pkg::BASE_W-1:0] cfg_wr_data,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [63:0]                in_tdata,
  input  logic                       in_tuser,
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [7:0]                 out_tdata,
  input  logic                       out_tlast,
  output int                         mismatch_count,
  output int                         digits_pending
);
  import rdc_pkg::*;

  localparam int FRACTION_LIMIT =
    (MAX_FRACTION_DIGITS < RESULT_CAP) ? MAX_FRACTION_DIGITS : RESULT_CAP;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               is_last;
  } digit_beat_t;

  digit_beat_t       digits_due[$];
  logic [BASE_W-1:0] base_reg = BASE_RESET;
  int                mismatch_total = 0;
  int                due_count = 0;
  int                out_beats = 0;

  assign mismatch_count = mismatch_total;
  assign digits_pending = due_count;

  task automatic report_mismatch(input string msg);
    if (mismatch_total < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_total++;
  endtask

  // queues the digits that one input beat must produce under the current base
  function automatic void predict_digits(input logic act, input logic [VALUE_W-1:0] val);
    logic [BASE_W-1:0] b;
    logic [63:0]       radix;
    logic [63:0]       whole;
    logic [63:0]       frac;
    logic [63:0]       prod;
    logic [63:0]       mask;
    logic [DIGIT_W-1:0] d;
    int                n;
    b = base_reg;
    if (b < BASE_MIN) begin
      b = BASE_MIN;
    end else if (b > BASE_MAX) begin
      b = BASE_MAX;
    end
    radix = 64'(b);
    mask  = (64'd1 << FRACTION_BITS) - 64'd1;
    n     = 0;
    if (act == ACT_INTEGER) begin
      whole = 64'(val);
      if (whole == 64'd0) begin
        digits_due.push_back('{digit: '0, is_last: 1'b1});
      end
      while (whole != 64'd0 && n < RESULT_CAP) begin
        d     = DIGIT_W'(whole % radix);
        whole = whole / radix;
        n++;
        digits_due.push_back('{digit: d, is_last: (whole == 64'd0 || n == RESULT_CAP)});
      end
    end else begin
      frac = 64'(val) & mask;
      while (frac != 64'd0 && n < FRACTION_LIMIT) begin
        prod = frac * radix;
        d    = DIGIT_W'(prod >> FRACTION_BITS);
        frac = prod & mask;
        n++;
        digits_due.push_back('{digit: d, is_last: (frac == 64'd0 || n == FRACTION_LIMIT)});
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    digit_beat_t want;
    if (!rst_n) begin
      base_reg <= BASE_RESET;
      digits_due.delete();
      due_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        out_beats++;
        if (digits_due.size() == 0) begin
          report_mismatch($sformatf("result beat %0d: digit %0d with nothing pending",
                                    out_beats, out_tdata[DIGIT_W-1:0]));
        end else begin
          want = digits_due.pop_front();
          if (out_tdata[DIGIT_W-1:0] !== want.digit) begin
            report_mismatch($sformatf("result beat %0d: digit %0d, expected %0d",
                                      out_beats, out_tdata[DIGIT_W-1:0], want.digit));
          end
          if (out_tlast !== want.is_last) begin
            report_mismatch($sformatf("result beat %0d: last flag %b, expected %b",
                                      out_beats, out_tlast, want.is_last));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_digits(in_tuser, in_tdata[VALUE_W-1:0]);
      end
      if (cfg_wr_en) begin
        base_reg <= cfg_wr_data;
      end
      due_count <= digits_due.size();
    end
  end

endmodule

// ===== bench/radix_digit_converter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_unit_tb
// drives integer and fraction conversions through the radix digit converter
// under several bases, including out-of-range ones, with bursty input and a
// stalling result side; the checker beside the block predicts every digit
// ----------------------------------------------------------------------------
module radix_digit_converter_unit_tb;
  import rdc_pkg::*;

  localparam int MAX_FRACTION_DIGITS = 45;
  localparam int FRACTION_BITS       = 48;

  // slowest legal run: every beat 63 integer digits plus receiver stalls,
  // about 250 beats; the limit is several times that
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int HOLD_CYCLES   = 400;   // one long result-side hold-off
  localparam int SETTLE_CYCLES = 20;    // quiet margin before a base write
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 40;

  localparam logic [VALUE_W-1:0] VALUE_MAX = '1;
  localparam logic [VALUE_W-1:0] FRAC_LSB  = VALUE_W'(1);
  localparam logic [VALUE_W-1:0] FRAC_HALF = VALUE_W'(64'd1 << (FRACTION_BITS - 1));
  localparam logic [VALUE_W-1:0] FRAC_ONES = VALUE_W'((64'd1 << FRACTION_BITS) - 64'd1);
  localparam logic [VALUE_W-1:0] HIGH_ONLY = VALUE_W'(64'd1 << (VALUE_W - 1));

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PATTERN} ready_mode_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_wr_en    = 1'b0;
  logic [BASE_W-1:0]  cfg_wr_data  = '0;
  logic               in_tvalid    = 1'b0;
  logic               in_tready;
  logic [63:0]        in_tdata     = '0;   // [62:0] value, [63] zero
  logic               in_tuser     = 1'b0; // [0] action
  logic               out_tvalid;
  logic               out_tready   = 1'b0;
  logic [7:0]         out_tdata;           // [3:0] digit, [7:4] zero
  logic               out_tlast;           // is_last
  logic               hold_off_req = 1'b0;
  int                 mismatch_count;
  int                 digits_pending;
  int                 burst_left   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  radix_digit_converter_unit #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
    .FRACTION_BITS       (FRACTION_BITS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  radix_digit_checker #(
    .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS),
    .FRACTION_BITS       (FRACTION_BITS)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .digits_pending (digits_pending)
  );

  // offers one conversion beat and returns at the edge that accepts it;
  // beats go out in bursts, with a gap of random length between bursts
  task automatic send_item(input logic act, input logic [VALUE_W-1:0] val);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4))
        @(posedge clk);
      // now and then a long burst, so stretches without input gaps occur
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {1'b0, val};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stops input, waits for every owed digit, lets the sequencer settle,
  // then writes the base register while the block is idle
  task automatic set_base(input logic [BASE_W-1:0] b);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (digits_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= b;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // result side: the stall pattern changes at random among four modes; once asked,
  // hold off for a long stretch so the block backs up and stalls its input
  initial begin : receiver
    ready_mode_t mode;
    int          mode_left;
    int          tick;
    bit          held;
    mode      = READY_ALWAYS;
    mode_left = 0;
    tick      = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (mode_left == 0) begin
        mode      = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        READY_ALWAYS: out_tready <= 1'b1;
        READY_MOSTLY: out_tready <= ($urandom_range(0, 3) != 0);
        READY_RARELY: out_tready <= ($urandom_range(0, 3) == 0);
        default:      out_tready <= (tick % 3 != 0);
      endcase
    end
  end

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    logic              act;
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] val;
    logic [BASE_W-1:0]  b;
    int                 sh;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // base 10 straight from reset
    send_item(ACT_INTEGER,  '0);              // zero gives one digit 0
    send_item(ACT_INTEGER,  VALUE_MAX);
    send_item(ACT_INTEGER,  VALUE_W'(1));
    send_item(ACT_INTEGER,  VALUE_W'(10));
    send_item(ACT_FRACTION, '0);              // zero fraction gives no digit
    send_item(ACT_FRACTION, HIGH_ONLY);       // bits above the fraction are ignored
    send_item(ACT_FRACTION, FRAC_HALF);
    send_item(ACT_FRACTION, FRAC_LSB);        // needs 48 digits, cut at the digit limit
    send_item(ACT_FRACTION, VALUE_MAX);

    // smallest base: longest integer sequence
    set_base(BASE_MIN);
    send_item(ACT_INTEGER,  VALUE_MAX);
    send_item(ACT_FRACTION, FRAC_LSB);        // limit hit before the only one bit
    send_item(ACT_FRACTION, FRAC_HALF | FRAC_LSB);

    // largest base
    set_base(BASE_MAX);
    send_item(ACT_INTEGER,  VALUE_MAX);
    send_item(ACT_FRACTION, FRAC_ONES);
    send_item(ACT_INTEGER,  VALUE_W'(16));

    // out-of-range bases clamp to the nearest legal one
    set_base(BASE_W'(0));
    send_item(ACT_INTEGER,  VALUE_W'(5));
    send_item(ACT_FRACTION, FRAC_HALF >> 1);
    set_base(BASE_W'(31));
    send_item(ACT_INTEGER,  VALUE_W'(255));
    send_item(ACT_FRACTION, VALUE_MAX);
    set_base(BASE_W'(1));
    send_item(ACT_INTEGER,  VALUE_W'(3));
    set_base(BASE_W'(17));
    send_item(ACT_INTEGER,  VALUE_W'(17));

    // base 3: a half never terminates, so the digit limit ends it
    set_base(BASE_W'(3));
    send_item(ACT_FRACTION, FRAC_HALF);
    send_item(ACT_INTEGER,  VALUE_MAX);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if ($urandom_range(0, 3) == 0) begin
        b = BASE_W'($urandom_range(0, 31));
      end else begin
        b = BASE_W'($urandom_range(2, 16));
      end
      set_base(b);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // long result hold-off while input keeps coming
        if (phase == 1 && i == 3) begin
          hold_off_req <= 1'b1;
        end
        act = 1'($urandom_range(0, 1));
        raw = VALUE_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
          0: val = raw;
          1: begin
            sh  = $urandom_range(0, VALUE_W - 1);
            val = raw >> sh;
          end
          2: val = VALUE_W'($urandom_range(0, 40));
          default: begin
            // few fraction bits set near the top, so fractions end early
            sh  = $urandom_range(FRACTION_BITS - 12, FRACTION_BITS);
            val = (raw >> sh) << sh;
          end
        endcase
        send_item(act, val);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (digits_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
